[design/wosc_pkg.sv]
package wosc_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_LOG2_POINTS_DEF = 11;
    localparam int SAMPLE_BITS_DEF     = 24;

    // Input transaction fields
    localparam int CMD_W   = 2;
    localparam int FREQ_W  = 32;
    localparam int ADDR_W  = 12;
    localparam int VAL_W   = 24;
    localparam int PHASE_W = 32;

    // Packing of s_axis_tdata, lowest field first
    localparam int FREQ_LSB   = 0;
    localparam int ADDR_LSB   = FREQ_LSB + FREQ_W;
    localparam int VAL_LSB    = ADDR_LSB + ADDR_W;
    localparam int PHASE_LSB  = VAL_LSB + VAL_W;
    localparam int S_FIELDS_W = PHASE_LSB + PHASE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 36;
    localparam int LP_W      = 4;
    localparam int LPE_W     = 5;

    localparam logic [LP_W-1:0]  LOG2_POINTS_RST = 4'd9;
    localparam logic [CFG_W-1:0] INC_SCALE_RST   = 36'd5864062015;

    // Interpolation arithmetic
    localparam int FRAC_W  = 16;
    localparam int COEF_W  = 28;
    localparam int T_W     = 48;
    localparam int PROD_W  = T_W + FRAC_W + 1;
    localparam int PINC_W  = FREQ_W + PHASE_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_PHASE  = 2'd2
    } cmd_e_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOG2_POINTS = 2'd0,
        REG_TABLE_VALID = 2'd1,
        REG_INC_SCALE   = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_GATHER,
        ST_COEF,
        ST_MUL0,
        ST_ACC0,
        ST_MUL1,
        ST_ACC1,
        ST_MUL2,
        ST_ACC2,
        ST_OUT
    } state_t;

    typedef enum logic {
        MSEL_C3,
        MSEL_T
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_C2,
        ACC_C1,
        ACC_B
    } acc_sel_t;

    typedef struct packed {
        logic     capture;
        logic     tbl_wr;
        logic     ph_load;
        logic     clr_t;
        logic     rd_en;
        logic [1:0] rd_ofs;
        logic     word_shift;
        logic     coef_en;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_en;
        acc_sel_t acc_sel;
        logic     ph_mul;
        logic     ph_upd;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic table_valid;
    } dp_stat_t;

endpackage

[design/wosc_ctrl.sv]
module wosc_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic [wosc_pkg::CMD_W-1:0]   s_cmd,
    output logic                         s_ready,
    output logic                         m_valid,
    input  logic                         m_ready,
    input  wosc_pkg::dp_stat_t           stat,
    output wosc_pkg::dp_cmd_t            cmd
);
    import wosc_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] rd_cnt_reg, rd_cnt_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // Next state
    always_comb begin
        state_next  = state_reg;
        rd_cnt_next = 2'd0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && cmd_e_t'(s_cmd) == CMD_SAMPLE) begin
                    state_next = stat.table_valid ? ST_READ : ST_OUT;
                end
            end
            ST_READ: begin
                rd_cnt_next = 2'(rd_cnt_reg + 2'd1);
                if (rd_cnt_reg == 2'd3) begin
                    state_next = ST_GATHER;
                end
            end
            ST_GATHER: state_next = ST_COEF;
            ST_COEF:   state_next = ST_MUL0;
            ST_MUL0:   state_next = ST_ACC0;
            ST_ACC0:   state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_ACC1;
            ST_ACC1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_ACC2;
            ST_ACC2:   state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        cmd     = '0;
        s_ready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (cmd_e_t'(s_cmd))
                        CMD_SAMPLE: begin
                            cmd.capture = 1'b1;
                            cmd.clr_t   = !stat.table_valid;
                        end
                        CMD_WRITE: cmd.tbl_wr  = 1'b1;
                        CMD_PHASE: cmd.ph_load = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                cmd.rd_en      = 1'b1;
                cmd.rd_ofs     = rd_cnt_reg;
                cmd.word_shift = (rd_cnt_reg != 2'd0);
            end
            ST_GATHER: cmd.word_shift = 1'b1;
            ST_COEF:   cmd.coef_en    = 1'b1;
            ST_MUL0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_C3;
                cmd.ph_mul  = 1'b1;
            end
            ST_ACC0: begin
                cmd.acc_en  = 1'b1;
                cmd.acc_sel = ACC_C2;
            end
            ST_MUL1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_T;
            end
            ST_ACC1: begin
                cmd.acc_en  = 1'b1;
                cmd.acc_sel = ACC_C1;
            end
            ST_MUL2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_T;
            end
            ST_ACC2: begin
                cmd.acc_en  = 1'b1;
                cmd.acc_sel = ACC_B;
            end
            ST_OUT: begin
                cmd.out_load = out_free;
                cmd.ph_upd   = out_free && stat.table_valid;
            end
            default: ;
        endcase
    end

    // Output valid: set on load, drop once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_cnt_reg  <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_cnt_reg  <= rd_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("output register loaded while a result is still pending");

    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside the output state");

    a_side_effects_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.tbl_wr || cmd.ph_load || cmd.capture) |-> (s_valid && s_ready))
        else $error("table or phase touched without an accepted transaction");

    a_four_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GATHER) |-> ($past(state_reg == ST_READ) && $past(rd_cnt_reg) == 2'd3))
        else $error("gather entered before all four table reads were issued");
`endif

endmodule

[design/wosc_dp.sv]
module wosc_dp #(
    parameter int MAX_LOG2_POINTS = wosc_pkg::MAX_LOG2_POINTS_DEF,
    parameter int SAMPLE_BITS     = wosc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [wosc_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [wosc_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic signed [wosc_pkg::FREQ_W-1:0]  s_freq,
    input  logic [wosc_pkg::ADDR_W-1:0]         s_table_addr,
    input  logic signed [wosc_pkg::VAL_W-1:0]   s_table_value,
    input  logic [wosc_pkg::PHASE_W-1:0]        s_new_phase,
    input  wosc_pkg::dp_cmd_t                   cmd,
    output wosc_pkg::dp_stat_t                  stat,
    output logic [SAMPLE_BITS-1:0]              sample
);
    import wosc_pkg::*;

    localparam int DEPTH = (1 << MAX_LOG2_POINTS) + 3;
    localparam int AW    = MAX_LOG2_POINTS + 1;
    localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(32768);
    localparam logic signed [T_W-1:0]    HALF_Y = T_W'(65536);
    localparam logic signed [T_W-1:0]    SMAX   =
        T_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [T_W-1:0]    SMIN   = T_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    // Configuration registers
    logic [LP_W-1:0]  lp_reg;
    logic             tv_reg;
    logic [CFG_W-1:0] scale_reg;

    // Phase and per-sample captures
    logic [PHASE_W-1:0]              phase_reg;
    logic signed [FREQ_W-1:0]        freq_reg;
    logic [MAX_LOG2_POINTS-1:0]      idx_reg;
    logic [FRAC_W-1:0]               f_reg;
    logic signed [PINC_W-1:0]        pinc_reg;

    // Table and gathered words
    logic [VAL_W-1:0]        mem [DEPTH];
    logic signed [VAL_W-1:0] rdata_reg;
    logic signed [VAL_W-1:0] wa_reg, wb_reg, wc_reg, wd_reg;

    // Horner datapath
    logic signed [COEF_W-1:0] c1_reg, c2_reg, c3_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [T_W-1:0]    t_reg;
    logic [SAMPLE_BITS-1:0]   sample_reg;

    logic [LPE_W-1:0]         lp_ext, lp_eff;
    logic [PHASE_W-1:0]       ph_shl, ph_shr;
    logic [31:0]              wr_addr32;
    logic                     wr_ok;
    logic [AW-1:0]            rd_addr;
    logic signed [COEF_W-1:0] a28, b28, c28, d28;
    logic signed [COEF_W-1:0] c1_next, c2_next, c3_next;
    logic signed [T_W-1:0]    mul_a;
    logic signed [PROD_W-1:0] rs_sum, rs_shift;
    logic signed [T_W-1:0]    kterm, addend, t_next;
    logic signed [T_W-1:0]    y_sum, y_val, y_sat;
    logic [PHASE_W-1:0]       inc32;

    assign stat.table_valid = tv_reg;
    assign sample           = sample_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lp_reg    <= LOG2_POINTS_RST;
            tv_reg    <= 1'b0;
            scale_reg <= INC_SCALE_RST;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_addr))
                REG_LOG2_POINTS: lp_reg    <= cfg_wdata[LP_W-1:0];
                REG_TABLE_VALID: tv_reg    <= cfg_wdata[0];
                REG_INC_SCALE:   scale_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp the point count and split the phase into index and fraction
    always_comb begin
        lp_ext = {1'b0, lp_reg};
        if (lp_ext == '0) begin
            lp_eff = LPE_W'(1);
        end else if (lp_ext > LPE_W'(MAX_LOG2_POINTS)) begin
            lp_eff = LPE_W'(MAX_LOG2_POINTS);
        end else begin
            lp_eff = lp_ext;
        end
        ph_shl = phase_reg << lp_eff;
        ph_shr = phase_reg >> (6'd32 - {1'b0, lp_eff});
    end

    // Capture the operands of a sample
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            freq_reg <= s_freq;
            idx_reg  <= ph_shr[MAX_LOG2_POINTS-1:0];
            f_reg    <= ph_shl[PHASE_W-1 -: FRAC_W];
        end
    end

    // Phase increment: low partial product first, then fold in the top bits
    assign inc32 = PHASE_W'($unsigned(freq_reg) * {28'd0, scale_reg[CFG_W-1:32]})
                 + $unsigned(pinc_reg[63:32]);

    always_ff @(posedge aclk) begin
        if (cmd.ph_mul) begin
            pinc_reg <= freq_reg * $signed({1'b0, scale_reg[31:0]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (cmd.ph_load) begin
            phase_reg <= s_new_phase;
        end else if (cmd.ph_upd) begin
            phase_reg <= phase_reg + inc32;
        end
    end

    // Table memory: one write port, one registered read port
    assign wr_addr32 = 32'(s_table_addr);
    assign wr_ok     = (wr_addr32 < 32'(DEPTH));
    assign rd_addr   = AW'(idx_reg) + AW'(cmd.rd_ofs);

    always_ff @(posedge aclk) begin
        if (cmd.tbl_wr && wr_ok) begin
            mem[wr_addr32[AW-1:0]] <= s_table_value;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Shift read words in at the d end
    always_ff @(posedge aclk) begin
        if (cmd.word_shift) begin
            wa_reg <= wb_reg;
            wb_reg <= wc_reg;
            wc_reg <= wd_reg;
            wd_reg <= rdata_reg;
        end
    end

    // Doubled Hermite coefficients
    always_comb begin
        a28     = COEF_W'(wa_reg);
        b28     = COEF_W'(wb_reg);
        c28     = COEF_W'(wc_reg);
        d28     = COEF_W'(wd_reg);
        c1_next = c28 - a28;
        c2_next = (a28 <<< 1) - ((b28 <<< 2) + b28) + (c28 <<< 2) - d28;
        c3_next = (d28 - a28) + ((b28 - c28) <<< 1) + (b28 - c28);
    end

    always_ff @(posedge aclk) begin
        if (cmd.coef_en) begin
            c1_reg <= c1_next;
            c2_reg <= c2_next;
            c3_reg <= c3_next;
        end
    end

    // Shared multiplier by the fraction
    assign mul_a = (cmd.mul_sel == MSEL_C3) ? T_W'(c3_reg) : t_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= mul_a * $signed({1'b0, f_reg});
        end
    end

    // Horner accumulate, with round-half-up on the scaled product in the C1 and B steps
    always_comb begin
        rs_sum   = prod_reg + HALF_P;
        rs_shift = rs_sum >>> FRAC_W;
        case (cmd.acc_sel)
            ACC_C2: begin
                kterm  = T_W'(c2_reg) <<< FRAC_W;
                addend = T_W'(prod_reg);
            end
            ACC_C1: begin
                kterm  = T_W'(c1_reg) <<< FRAC_W;
                addend = T_W'(rs_shift);
            end
            ACC_B: begin
                kterm  = T_W'(wb_reg) <<< (FRAC_W + 1);
                addend = T_W'(rs_shift);
            end
            default: begin
                kterm  = '0;
                addend = '0;
            end
        endcase
        t_next = kterm + addend;
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_t) begin
            t_reg <= '0;
        end else if (cmd.acc_en) begin
            t_reg <= t_next;
        end
    end

    // Round, saturate and hold the result
    always_comb begin
        y_sum = t_reg + HALF_Y;
        y_val = y_sum >>> (FRAC_W + 1);
        if (y_val > SMAX) begin
            y_sat = SMAX;
        end else if (y_val < SMIN) begin
            y_sat = SMIN;
        end else begin
            y_sat = y_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            sample_reg <= SAMPLE_BITS'(y_sat);
        end
    end

endmodule

[design/wavetable_osc_hermite_top.sv]
// Wavetable oscillator with 4-point cubic Hermite interpolation.
// Input stream (s_axis_*): tuser carries the command, tdata the operands.
//   cmd 0 produces one sample and, with a valid table, advances the phase by the scaled frequency,
//   cmd 1 writes one table word, cmd 2 loads the phase, cmd 3 is dropped.
// Output stream (m_axis_*): one sample per cmd 0, nothing for other commands.
// Configuration: cfg_we/cfg_addr/cfg_wdata write log2_points (0),
//   table_valid (1) and inc_scale (2); write them only while the block is idle.
// Sequence: cmd 1, 2 and 3 complete in the idle state. A cmd 0 with a loaded
//   table runs four reads of the single table read port, a gather step, a
//   coefficient step, three Horner steps that share one multiplier (a multiply
//   and an accumulate step each) and an output step, then raises m_axis_tvalid
//   from the output register. No new transaction is accepted until the sample's
//   sequence is back in idle. With no valid table a cmd 0 goes straight to the
//   output step and gives a zero sample.
// A finished sample waits in an output register; the next transaction is
//   accepted meanwhile, and a later sample stalls in its final state until the
//   receiver takes the pending one. Nothing is lost under backpressure.
// Reset (aresetn low, synchronous) clears the phase and the handshake state
//   and restores the register defaults; the table is left as it is.
module wavetable_osc_hermite_top #(
    parameter int MAX_LOG2_POINTS = wosc_pkg::MAX_LOG2_POINTS_DEF,
    parameter int SAMPLE_BITS     = wosc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // freq[31:0], table_addr[43:32], table_value[67:44], new_phase[99:68], zero
    input  logic [wosc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // cmd[1:0]
    input  logic [wosc_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // sample[SAMPLE_BITS-1:0], zero above
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [wosc_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [wosc_pkg::CFG_W-1:0]        cfg_wdata
);
    import wosc_pkg::*;

    localparam int M_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    dp_cmd_t                 dp_cmd;
    dp_stat_t                dp_stat;
    logic [SAMPLE_BITS-1:0]  sample;

    wosc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_cmd   (s_axis_tuser),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    wosc_dp #(
        .MAX_LOG2_POINTS (MAX_LOG2_POINTS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_freq        ($signed(s_axis_tdata[FREQ_LSB +: FREQ_W])),
        .s_table_addr  (s_axis_tdata[ADDR_LSB +: ADDR_W]),
        .s_table_value ($signed(s_axis_tdata[VAL_LSB +: VAL_W])),
        .s_new_phase   (s_axis_tdata[PHASE_LSB +: PHASE_W]),
        .cmd           (dp_cmd),
        .stat          (dp_stat),
        .sample        (sample)
    );

    // Zero-fill the sample up to whole bytes
    assign m_axis_tdata = M_TDATA_W'(sample);

endmodule
